// ----- rtl/core/lrup_pkg.sv -----
package lrup_pkg;

    // Built size of the recency row and stored page width
    localparam int SLOTS     = 16;
    localparam int PAGE_BITS = 16;

    // Fixed field widths of the ports
    localparam int ID_W    = 16;
    localparam int CAP_W   = 5;
    localparam int COUNT_W = 32;

    // Occupancy must hold 0..SLOTS
    localparam int OCC_W = $clog2(SLOTS + 1);

    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [ID_W-1:0]      page_id_t;
    typedef logic [CAP_W-1:0]     cap_t;
    typedef logic [OCC_W-1:0]     occ_t;
    typedef logic [COUNT_W-1:0]   count_t;

    // Per-cell control from the row sequencer
    typedef struct packed {
        logic en;        // word accepted this cycle
        logic in_use;    // cell index below occupancy
        logic is_tail;   // cell takes the accessed page
        logic shift_ok;  // right neighbor is in use
        logic evict;     // miss with occupancy at capacity
    } cell_ctrl_t;

    // Keep the low PAGE_BITS bits of a port page number
    function automatic page_t to_page(input page_id_t id);
        logic [31:0] wide;
        wide = 32'(id);
        return wide[PAGE_BITS-1:0];
    endfunction

    // Return a stored page at port width
    function automatic page_id_t to_id(input page_t p);
        logic [31:0] wide;
        wide = 32'(p);
        return wide[ID_W-1:0];
    endfunction

endpackage

// ----- rtl/core/lru_page_replacement.sv -----
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall   | page_id
// out     | output    | out_valid/out_stall | hit, victim_valid, victim_page,
//         |           |                     | access_total, miss_total
// cfg     | input     | cfg_valid/cfg_ready | capacity_in_use
//
// One word per cycle: the compare and the shift across the cell row finish
// in the cycle the word is accepted, and the result shows in the next cycle.
// The result register frees in the same cycle it is taken, so words flow
// back to back while out_stall stays low.
// Reset clears occupancy, both counters, the result valid, and sets the
// capacity to 16; page entries above occupancy are never read.
// in_stall is high while a result waits under out_stall.
module lru_page_replacement (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  lrup_pkg::page_id_t   page_id,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 hit,
    output logic                 victim_valid,
    output lrup_pkg::page_id_t   victim_page,
    output lrup_pkg::count_t     access_total,
    output lrup_pkg::count_t     miss_total,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  lrup_pkg::cap_t       capacity_in_use
);
    import lrup_pkg::*;

    cap_t       cap_reg;
    occ_t       occ_reg;
    occ_t       occ_next;
    count_t     acc_reg;
    count_t     acc_next;
    count_t     miss_reg;
    count_t     miss_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       hit_reg;
    logic       victim_valid_reg;
    page_id_t   victim_page_reg;

    logic       accept;
    page_t      page;
    occ_t       cap_eff;
    logic       row_hit;
    logic       room;
    logic       append;
    logic       evict;
    occ_t       tail_idx;

    page_t      entry [SLOTS];
    logic       seen  [SLOTS+1];
    cell_ctrl_t ctrl  [SLOTS];

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign page      = to_page(page_id);

    // Clamp the capacity to 1..SLOTS
    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = OCC_W'(1);
        else if (32'(cap_reg) > 32'(SLOTS))
            cap_eff = OCC_W'(SLOTS);
        else
            cap_eff = OCC_W'(cap_reg);
    end

    assign row_hit  = seen[SLOTS];
    assign room     = occ_reg < cap_eff;
    assign append   = !row_hit && room;
    assign evict    = !row_hit && !room;
    assign tail_idx = append ? occ_reg : occ_reg - OCC_W'(1);

    // Build the cell row
    assign seen[0] = 1'b0;
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        page_t right_entry;

        if (i == SLOTS - 1)
        begin : g_last
            assign right_entry = entry[i];
        end
        else
        begin : g_mid
            assign right_entry = entry[i+1];
        end

        assign ctrl[i].en       = accept;
        assign ctrl[i].in_use   = 32'(i) < 32'(occ_reg);
        assign ctrl[i].is_tail  = 32'(tail_idx) == 32'(i);
        assign ctrl[i].shift_ok = 32'(i + 1) < 32'(occ_reg);
        assign ctrl[i].evict    = evict;

        lrup_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl[i]),
            .page        (page),
            .right_entry (right_entry),
            .seen_in     (seen[i]),
            .entry       (entry[i]),
            .seen_out    (seen[i+1])
        );
    end

    // Advance occupancy and counters on each accepted word
    always_comb
    begin
        occ_next  = occ_reg;
        acc_next  = acc_reg;
        miss_next = miss_reg;
        if (accept)
        begin
            acc_next = acc_reg + COUNT_W'(1);
            if (!row_hit)
                miss_next = miss_reg + COUNT_W'(1);
            if (append)
                occ_next = occ_reg + OCC_W'(1);
        end
    end

    // Hold the result until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_W'(16);
            occ_reg       <= '0;
            acc_reg       <= '0;
            miss_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cap_reg <= capacity_in_use;
            occ_reg       <= occ_next;
            acc_reg       <= acc_next;
            miss_reg      <= miss_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the result fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg          <= row_hit;
            victim_valid_reg <= evict;
            victim_page_reg  <= evict ? to_id(entry[0]) : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign victim_valid = victim_valid_reg;
    assign victim_page  = victim_page_reg;
    assign access_total = acc_reg;
    assign miss_total   = miss_reg;

endmodule

// ----- rtl/core/lrup_cell.sv -----
module lrup_cell (
    input  logic               clk,
    input  lrup_pkg::cell_ctrl_t ctrl,
    input  lrup_pkg::page_t    page,
    input  lrup_pkg::page_t    right_entry,
    input  logic               seen_in,
    output lrup_pkg::page_t    entry,
    output logic               seen_out
);
    import lrup_pkg::*;

    page_t entry_reg;
    page_t entry_next;
    logic  match;

    // Compare the stored page against the access
    assign match    = ctrl.in_use && (entry_reg == page);
    // Pass on whether the hit lies at or left of this cell
    assign seen_out = seen_in | match;
    assign entry    = entry_reg;

    // Take the page at the tail, else close the gap from the right
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.en)
        begin
            if (ctrl.is_tail)
                entry_next = page;
            else if (ctrl.shift_ok && (seen_out || ctrl.evict))
                entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- rtl/core/lrup_checker.sv -----
module lrup_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               hit,
    input logic               victim_valid,
    input lrup_pkg::page_id_t victim_page,
    input lrup_pkg::count_t   access_total,
    input lrup_pkg::count_t   miss_total
);
    import lrup_pkg::*;

    // Each accepted word advances the access count by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (access_total == $past(access_total) + COUNT_W'(1)))
    else $error("access count did not advance by one");

    // The miss count advances exactly on a miss
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (miss_total == $past(miss_total) + COUNT_W'(!hit)))
    else $error("miss count disagrees with hit flag");

    // An eviction is only reported on a miss, and no victim reads as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!(victim_valid && hit) && (victim_valid || victim_page == '0)))
    else $error("victim fields inconsistent with hit");

    // A stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(victim_page) && $stable(hit)))
    else $error("stalled result word changed");

endmodule

bind lru_page_replacement lrup_checker u_lrup_checker (.*);
